// File: sv/mrsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsd_pkg
// Types and constants shared by the move record stream decoder.
// ----------------------------------------------------------------------------
package mrsd_pkg;

  // field widths of the result channel
  localparam int DIR_W      = 9;
  localparam int TICK_OUT_W = 32;
  localparam int BYTE_W     = 8;

  // widest tick increment of any record: 27 data bits plus one
  localparam int DELTA_W    = 28;

  // record format codes, taken from the low two bits of the first byte
  localparam logic [1:0] FMT_TRIPLE = 2'd0;
  localparam logic [1:0] FMT_SHORT  = 2'd1;
  localparam logic [1:0] FMT_MEDIUM = 2'd2;
  localparam logic [1:0] FMT_LONG   = 2'd3;

  // one decoded move, as held in the job queue and the output register
  typedef struct packed {
    logic [DIR_W-1:0]      direction;
    logic [TICK_OUT_W-1:0] tick;
    logic                  status;
    logic                  last_of_run;
    logic                  end_of_data;
  } move_t;

  // direction index to nine-bit direction mask
  function automatic logic [DIR_W-1:0] dir_of_index(input logic [2:0] idx);
    logic [DIR_W-1:0] mask;
    unique case (idx)
      3'd0: mask = 9'd1;
      3'd1: mask = 9'd2;
      3'd2: mask = 9'd4;
      3'd3: mask = 9'd8;
      3'd4: mask = 9'd3;
      3'd5: mask = 9'd6;
      3'd6: mask = 9'd9;
      3'd7: mask = 9'd12;
    endcase
    return mask;
  endfunction

  // record length in bytes, fixed by the first byte
  function automatic logic [2:0] record_length(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    unique case (b[1:0])
      FMT_TRIPLE: len = 3'd1;
      FMT_SHORT:  len = 3'd1;
      FMT_MEDIUM: len = 3'd2;
      FMT_LONG:   len = b[4] ? (3'd2 + {1'b0, b[3:2]}) : 3'd4;
    endcase
    return len;
  endfunction

endpackage

// File: sv/move_record_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_record_stream_decoder_top
// Decodes a byte stream of 1 to 5 byte move records into timed moves.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one move byte per transfer; in_first_of_stream sets the running
//           tick to all ones and drops any open record, in_last_of_stream
//           marks the final byte of the move data.
//   out_* : one move per transfer with its absolute tick; a stream that ends
//           inside a record gives one result with status 1.
//   A byte gives zero, one or three results. It is decoded in the cycle it
//   is taken, placed in a three-entry job queue, and moves one result a
//   cycle into the output register unless that register is full and
//   stalled, so each result is registered in the job queue, then in the output register.
//   Throughput: one byte per cycle for bytes giving at most one result while
//   out_stall is low; a three-move byte holds off the next byte until its last
//   result leaves the queue; the single-result output register sets this figure.
//   Reset clears the record state, the job queue and the output register
//   and sets the tick to all ones. While out_stall is high the output
//   register holds; the queue takes the next byte once it is empty or its
//   last entry moves to the output register, and in_stall rises when it cannot.
// ----------------------------------------------------------------------------
module move_record_stream_decoder_top #(
  parameter int TICK_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrsd_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            in_first_of_stream,
  input  logic                            in_last_of_stream,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrsd_pkg::DIR_W-1:0]      out_direction,
  output logic [mrsd_pkg::TICK_OUT_W-1:0] out_tick,
  output logic                            out_status,
  output logic                            out_last_of_run,
  output logic                            out_end_of_data
);
  import mrsd_pkg::*;

  localparam int SUM_W = TICK_WIDTH + DELTA_W;

  // record and tick state
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [2:0]            bytes_expected_r, bytes_expected_nxt;
  logic [2:0]            bytes_collected_r, bytes_collected_nxt;
  logic [BYTE_W-1:0]     record_buf_r [4];

  // job queue and output register
  move_t                 job_r [3];
  move_t                 job_nxt [3];
  logic [1:0]            job_cnt_r, job_cnt_nxt;
  move_t                 out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // decode signals
  logic                  accept, pop, job_free;
  logic [2:0]            exp_eff, col_eff, pos, rec_len;
  logic                  open_rec, complete, truncate, triple;
  logic [BYTE_W-1:0]     rec [5];
  logic [1:0]            fmt;
  logic [1:0]            nx;
  logic [DELTA_W-2:0]    delta_raw;
  logic [DELTA_W-1:0]    delta;
  logic [DIR_W-1:0]      dir_a;
  logic [TICK_WIDTH-1:0] base;
  logic [SUM_W-1:0]      sum_a;
  logic [TICK_WIDTH-1:0] tick_a, tick_b, tick_c;
  move_t                 new_job [3];
  logic [1:0]            new_cnt;

  // handshakes
  assign pop      = (job_cnt_r != 2'd0) && (!out_valid_r || !out_stall);
  assign job_free = (job_cnt_r == 2'd0) || ((job_cnt_r == 2'd1) && pop);
  assign in_stall = !job_free;
  assign accept   = in_valid && !in_stall;

  // record position of the incoming byte
  always_comb begin
    exp_eff  = in_first_of_stream ? 3'd0 : bytes_expected_r;
    col_eff  = in_first_of_stream ? 3'd0 : bytes_collected_r;
    open_rec = (exp_eff != 3'd0);
    rec_len  = record_length(in_data_byte);
    complete = open_rec ? ((4'(col_eff) + 4'd1) >= 4'(exp_eff)) : (rec_len == 3'd1);
    truncate = in_last_of_stream && !complete;
    pos      = open_rec ? col_eff : 3'd0;
    for (int j = 0; j < 4; j++) begin
      rec[j] = (pos == 3'(j)) ? in_data_byte : record_buf_r[j];
    end
    rec[4] = in_data_byte;
  end

  // tick increment and direction of a complete record
  always_comb begin
    fmt       = rec[0][1:0];
    nx        = rec[0][3:2];
    triple    = (fmt == FMT_TRIPLE);
    delta_raw = '0;
    dir_a     = dir_of_index({1'b0, rec[0][3:2]});
    unique case (fmt)
      FMT_TRIPLE: begin
        dir_a = dir_of_index({1'b0, rec[0][3:2]});
      end
      FMT_SHORT: begin
        delta_raw = (DELTA_W-1)'(rec[0][7:5]);
        dir_a     = dir_of_index(rec[0][4:2]);
      end
      FMT_MEDIUM: begin
        delta_raw = (DELTA_W-1)'({rec[1], rec[0][7:5]});
        dir_a     = dir_of_index(rec[0][4:2]);
      end
      FMT_LONG: begin
        if (rec[0][4]) begin
          // raw direction, 2 to 5 byte record
          delta_raw = (DELTA_W-1)'({rec[4] & {BYTE_W{nx == 2'd3}},
                                    rec[3] & {BYTE_W{nx >= 2'd2}},
                                    rec[2] & {BYTE_W{nx >= 2'd1}},
                                    rec[1][7:6]});
          dir_a     = {rec[1][5:0], rec[0][7:5]};
        end else begin
          delta_raw = {rec[3], rec[2], rec[1], rec[0][7:5]};
          dir_a     = dir_of_index({1'b0, rec[0][3:2]});
        end
      end
    endcase
    delta = triple ? DELTA_W'(4) : (DELTA_W'(delta_raw) + DELTA_W'(1));
  end

  // new tick values
  always_comb begin
    base   = in_first_of_stream ? '1 : tick_r;
    sum_a  = SUM_W'(base) + SUM_W'(delta);
    tick_a = sum_a[TICK_WIDTH-1:0];
    tick_b = base + TICK_WIDTH'(8);
    tick_c = base + TICK_WIDTH'(12);
  end

  // results of the incoming byte
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      new_job[j]             = '0;
      new_job[j].end_of_data = in_last_of_stream;
    end
    new_cnt = 2'd0;
    if (complete) begin
      new_job[0].direction = dir_a;
      new_job[0].tick      = TICK_OUT_W'(tick_a);
      new_cnt              = 2'd1;
      if (triple) begin
        new_job[1].direction = dir_of_index({1'b0, rec[0][5:4]});
        new_job[1].tick      = TICK_OUT_W'(tick_b);
        new_job[2].direction = dir_of_index({1'b0, rec[0][7:6]});
        new_job[2].tick      = TICK_OUT_W'(tick_c);
        new_cnt              = 2'd3;
      end
    end else if (truncate) begin
      new_job[0].status = 1'b1;
      new_cnt           = 2'd1;
    end
  end

  // next record state and tick
  always_comb begin
    tick_nxt            = tick_r;
    bytes_expected_nxt  = bytes_expected_r;
    bytes_collected_nxt = bytes_collected_r;
    if (accept) begin
      tick_nxt = complete ? (triple ? tick_c : tick_a) : base;
      if (complete || truncate) begin
        bytes_expected_nxt  = 3'd0;
        bytes_collected_nxt = 3'd0;
      end else if (!open_rec) begin
        bytes_expected_nxt  = rec_len;
        bytes_collected_nxt = 3'd1;
      end else begin
        bytes_expected_nxt  = exp_eff;
        bytes_collected_nxt = col_eff + 3'd1;
      end
    end
  end

  // job queue and output register
  always_comb begin
    job_nxt     = job_r;
    job_cnt_nxt = job_cnt_r;
    if (accept) begin
      job_nxt     = new_job;
      job_cnt_nxt = new_cnt;
    end else if (pop) begin
      job_nxt[0]  = job_r[1];
      job_nxt[1]  = job_r[2];
      job_cnt_nxt = job_cnt_r - 2'd1;
    end
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_nxt             = job_r[0];
      out_nxt.last_of_run = (job_cnt_r == 2'd1);
      out_valid_nxt       = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r            <= '1;
      bytes_expected_r  <= 3'd0;
      bytes_collected_r <= 3'd0;
      job_cnt_r         <= 2'd0;
      out_valid_r       <= 1'b0;
    end else begin
      tick_r            <= tick_nxt;
      bytes_expected_r  <= bytes_expected_nxt;
      bytes_collected_r <= bytes_collected_nxt;
      job_cnt_r         <= job_cnt_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      record_buf_r[pos[1:0]] <= in_data_byte;
    end
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  // outputs
  assign out_valid       = out_valid_r;
  assign out_direction   = out_r.direction;
  assign out_tick        = out_r.tick;
  assign out_status      = out_r.status;
  assign out_last_of_run = out_r.last_of_run;
  assign out_end_of_data = out_r.end_of_data;

  // checks
  assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r != 2'd0 |-> job_cnt_r <= 2'd3)
    else $error("job queue count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    bytes_expected_r == 3'd0 |-> bytes_collected_r == 3'd0)
    else $error("bytes held with no open record");

  assert property (@(posedge clk) disable iff (!rst_n)
    bytes_expected_r != 3'd0 |-> (bytes_collected_r < bytes_expected_r &&
                                  bytes_collected_r != 3'd0))
    else $error("open record byte count inconsistent");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_of_run && out_end_of_data)
    else $error("truncation result not last of run and end of data");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_of_stream |=> bytes_expected_r == 3'd0)
    else $error("record left open after last byte");

endmodule

// File: bench/move_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_decode_checker
// Watches both channels of the move record stream decoder, keeps its own
// running tick and record buffer, predicts the moves of every byte transfer
// and compares each result transfer field by field against the oldest
// predicted move.
// ----------------------------------------------------------------------------
module move_decode_checker #(
  parameter int TICK_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [mrsd_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            in_first_of_stream,
  input  logic                            in_last_of_stream,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [mrsd_pkg::DIR_W-1:0]      out_direction,
  input  logic [mrsd_pkg::TICK_OUT_W-1:0] out_tick,
  input  logic                            out_status,
  input  logic                            out_last_of_run,
  input  logic                            out_end_of_data,
  output int                              error_count,
  output int                              pending_moves
);
  import mrsd_pkg::*;

  localparam logic STATUS_MOVE  = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  // direction masks for indices 0..7, nine bits each, index 0 lowest
  localparam logic [8*DIR_W-1:0] MASK_TABLE =
    {9'd12, 9'd9, 9'd6, 9'd3, 9'd8, 9'd4, 9'd2, 9'd1};

  // predictor state
  logic [TICK_WIDTH-1:0] run_tick;
  logic [BYTE_W-1:0]     held_bytes [0:3];
  logic [BYTE_W-1:0]     frame      [0:4];
  int                    open_len;
  int                    held;

  move_t expected_moves [$];
  move_t fresh_moves    [$];
  int    mismatches;

  assign error_count = mismatches;

  function automatic int frame_bytes(input logic [BYTE_W-1:0] lead);
    int span;
    case (lead[1:0])
      FMT_TRIPLE, FMT_SHORT: span = 1;
      FMT_MEDIUM:            span = 2;
      default:               span = lead[4] ? 2 + int'(lead[3:2]) : 4;
    endcase
    return span;
  endfunction

  // advance the running tick and record one decoded move
  task automatic emit_move(input logic [DIR_W-1:0] dir, input logic [63:0] delta);
    move_t mv;
    run_tick = run_tick + TICK_WIDTH'(delta);
    mv.direction   = dir;
    mv.tick        = TICK_OUT_W'(run_tick);
    mv.status      = STATUS_MOVE;
    mv.last_of_run = 1'b0;
    mv.end_of_data = 1'b0;
    fresh_moves.push_back(mv);
  endtask

  // decode the complete record held in frame
  task automatic decode_frame();
    logic [BYTE_W-1:0] lead;
    logic [63:0]       delta;
    int                idx;
    lead = frame[0];
    case (lead[1:0])
      FMT_TRIPLE: begin
        for (int i = 0; i < 3; i++) begin
          idx = (lead >> (2 + 2 * i)) & 3;
          emit_move(MASK_TABLE[idx*DIR_W +: DIR_W], 64'd4);
        end
      end
      FMT_SHORT: begin
        idx = lead[4:2];
        emit_move(MASK_TABLE[idx*DIR_W +: DIR_W], 64'(lead[7:5]) + 64'd1);
      end
      FMT_MEDIUM: begin
        idx   = lead[4:2];
        delta = 64'(lead[7:5]) + (64'(frame[1]) << 3) + 64'd1;
        emit_move(MASK_TABLE[idx*DIR_W +: DIR_W], delta);
      end
      default: begin
        if (lead[4]) begin
          // raw mouse direction, delay spread over the trailing bytes
          delta = 64'(frame[1][7:6]);
          for (int i = 0; i < int'(lead[3:2]); i++)
            delta = delta + (64'(frame[2+i]) << (2 + 8 * i));
          emit_move({frame[1][5:0], lead[7:5]}, delta + 64'd1);
        end else begin
          idx   = lead[3:2];
          delta = 64'({frame[3], frame[2], frame[1], lead[7:5]});
          emit_move(MASK_TABLE[idx*DIR_W +: DIR_W], delta + 64'd1);
        end
      end
    endcase
  endtask

  // expected moves caused by one byte transfer
  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic first,
                              input logic last);
    move_t cut;
    int    span;
    fresh_moves.delete();
    if (first) begin
      run_tick = '1;
      open_len = 0;
      held     = 0;
    end

    if (open_len == 0) begin
      span = frame_bytes(b);
      if (span == 1) begin
        for (int i = 0; i < 5; i++) frame[i] = '0;
        frame[0] = b;
        decode_frame();
      end else begin
        held_bytes[0] = b;
        held          = 1;
        open_len      = span;
      end
    end else if (held + 1 >= open_len) begin
      for (int i = 0; i < 5; i++) frame[i] = '0;
      for (int i = 0; i < held; i++) frame[i] = held_bytes[i];
      frame[held] = b;
      decode_frame();
      open_len = 0;
      held     = 0;
    end else begin
      held_bytes[held] = b;
      held++;
    end

    // stream ends inside a record
    if (last && open_len != 0) begin
      cut.direction   = '0;
      cut.tick        = '0;
      cut.status      = STATUS_TRUNC;
      cut.last_of_run = 1'b0;
      cut.end_of_data = 1'b0;
      fresh_moves.push_back(cut);
      open_len = 0;
      held     = 0;
    end

    if (fresh_moves.size() > 0)
      fresh_moves[fresh_moves.size()-1].last_of_run = 1'b1;
    foreach (fresh_moves[i]) begin
      fresh_moves[i].end_of_data = last;
      expected_moves.push_back(fresh_moves[i]);
    end
  endtask

  // compare result transfers, then predict from byte transfers
  always @(posedge clk) begin
    move_t want;
    if (!rst_n) begin
      run_tick   = '1;
      open_len   = 0;
      held       = 0;
      mismatches = 0;
      expected_moves.delete();
      pending_moves <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_moves.size() == 0) begin
          $error("unexpected result: direction %0d tick %0d status %0d",
                 out_direction, out_tick, out_status);
          mismatches++;
        end else begin
          want = expected_moves.pop_front();
          if (out_direction !== want.direction) begin
            $error("direction: expected %0d actual %0d", want.direction, out_direction);
            mismatches++;
          end
          if (out_tick !== want.tick) begin
            $error("tick: expected %0d actual %0d", want.tick, out_tick);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d actual %0d", want.last_of_run,
                   out_last_of_run);
            mismatches++;
          end
          if (out_end_of_data !== want.end_of_data) begin
            $error("end_of_data: expected %0d actual %0d", want.end_of_data,
                   out_end_of_data);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_byte(in_data_byte, in_first_of_stream, in_last_of_stream);
      pending_moves <= expected_moves.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives move bytes into the move record stream decoder: a directed run over
// every record format and the stream edge cases, then random bursts of
// well-formed, truncated, restarted and noisy streams, with random gaps on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic                            clk                = 1'b0;
  logic                            rst_n              = 1'b0;
  logic                            in_valid           = 1'b0;
  logic                            in_stall;
  logic [mrsd_pkg::BYTE_W-1:0]     in_data_byte       = '0;
  logic                            in_first_of_stream = 1'b0;
  logic                            in_last_of_stream  = 1'b0;
  logic                            out_valid;
  logic                            out_stall          = 1'b0;
  logic [mrsd_pkg::DIR_W-1:0]      out_direction;
  logic [mrsd_pkg::TICK_OUT_W-1:0] out_tick;
  logic                            out_status;
  logic                            out_last_of_run;
  logic                            out_end_of_data;

  int error_count;
  int pending_moves;
  int cycle_count = 0;
  int sent_count  = 0;
  int stall_left  = 0;
  int stall_draw;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;

  // {first, last, byte} per queued transfer
  bit [9:0] burst [$];

  move_record_stream_decoder_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_of_stream (in_first_of_stream),
    .in_last_of_stream  (in_last_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_direction      (out_direction),
    .out_tick           (out_tick),
    .out_status         (out_status),
    .out_last_of_run    (out_last_of_run),
    .out_end_of_data    (out_end_of_data)
  );

  move_decode_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_of_stream (in_first_of_stream),
    .in_last_of_stream  (in_last_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_direction      (out_direction),
    .out_tick           (out_tick),
    .out_status         (out_status),
    .out_last_of_run    (out_last_of_run),
    .out_end_of_data    (out_end_of_data),
    .error_count        (error_count),
    .pending_moves      (pending_moves)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // result side: after each transfer hold off for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = rx_quiet ? 0 : $urandom_range(0, 14);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // one byte transfer, preceded by a random gap
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_first_of_stream <= first;
    in_last_of_stream  <= last;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // stop sending until every predicted move has arrived
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_moves != 0);
  endtask

  // queue one record, or only its opening bytes when partial
  task automatic queue_record(input bit partial);
    logic [7:0] lead;
    int         span;
    int         n;
    lead = 8'($urandom);
    if (partial) lead[1] = 1'b1;
    span = int'(mrsd_pkg::record_length(lead));
    n    = partial ? $urandom_range(1, span - 1) : span;
    burst.push_back({2'b00, lead});
    for (int i = 1; i < n; i++) burst.push_back({2'b00, 8'($urandom)});
  endtask

  // one random stream: well-formed, truncated at the end, restarted
  // mid-record, or plain noise with random flags
  task automatic send_burst();
    int kind;
    int nrec;
    int restart_at;
    bit use_first;
    burst.delete();
    kind      = $urandom_range(0, 9);
    use_first = ($urandom_range(0, 7) != 0);
    tx_quiet  = ($urandom_range(0, 3) == 0);
    rx_quiet <= ($urandom_range(0, 3) == 0);
    if (kind == 9) begin
      repeat ($urandom_range(4, 16))
        burst.push_back({1'($urandom_range(0, 5) == 0), 1'($urandom_range(0, 5) == 0),
                         8'($urandom)});
    end else begin
      if (kind == 8) queue_record(1'b1);
      restart_at = burst.size();
      nrec = $urandom_range(1, 10);
      repeat (nrec) queue_record(1'b0);
      if (kind == 7) queue_record(1'b1);
      if (use_first) burst[0][9] = 1'b1;
      if (kind == 8) burst[restart_at][9] = 1'b1;
      burst[burst.size()-1][8] = 1'b1;
    end
    foreach (burst[i]) send_byte(burst[i][7:0], burst[i][9], burst[i][8]);
  endtask

  initial begin
    int random_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every format at its extremes, then the stream edge cases
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFC, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hFD, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hE3, 1'b0, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h13, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    repeat (5) send_byte(8'hFF, 1'b0, 1'b0);
    // record opened and ended by the same byte
    send_byte(8'h02, 1'b1, 1'b1);
    // continue from the kept tick, then restart inside an open record
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hA8, 1'b1, 1'b1);
    // truncated raw-direction record
    send_byte(8'h17, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    // completing byte carries the end flag
    send_byte(8'h45, 1'b0, 1'b0);
    send_byte(8'hE2, 1'b0, 1'b0);
    send_byte(8'h10, 1'b0, 1'b1);
    wait_drain();

    // random bursts, with an occasional full drain
    random_start = sent_count;
    while (sent_count - random_start < RANDOM_ITEMS) begin
      send_burst();
      if ($urandom_range(0, 7) == 0) wait_drain();
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
